### src/fsia_pkg.sv
// shared constants and types for the free stack id allocator
`default_nettype none

package fsia_pkg;

    localparam int ID_W              = 16;
    localparam int BASE_W            = 15;
    localparam int POOL_SIZE_DEFAULT = 4096;
    localparam logic [BASE_W-1:0] BASE_RESET = 15'd300;

    typedef enum logic [2:0] {
        ST_ALLOCATED    = 3'd0,
        ST_NONE_FREE    = 3'd1,
        ST_RELEASED     = 3'd2,
        ST_OUT_OF_RANGE = 3'd3,
        ST_NOT_IN_USE   = 3'd4
    } status_t;

    typedef enum logic {
        MODE_ALLOC   = 1'b0,
        MODE_RELEASE = 1'b1
    } mode_t;

endpackage

`default_nettype wire

### src/fsia_if.sv
// request and response channel interfaces for the id allocator
`default_nettype none

interface fsia_req_if;
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic [fsia_pkg::ID_W-1:0]  release_id;

    modport source (output valid, output mode, output release_id, input ready);
    modport sink   (input valid, input mode, input release_id, output ready);
endinterface

interface fsia_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [fsia_pkg::ID_W-1:0]  granted_id;
    logic [2:0]                 status;

    modport source (output valid, output granted_id, output status, input ready);
    modport sink   (input valid, input granted_id, input status, output ready);
endinterface

`default_nettype wire

### src/fsia_ram.sv
// generic simple dual port ram with registered read
`default_nettype none

module fsia_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### src/free_stack_id_allocator.sv
// free stack id allocator: lifo pool of identifiers with an in-use bit per identifier
//
// req channel carries one transaction per request: mode 0 allocates an identifier,
// mode 1 gives back release_id. rsp channel returns exactly one transaction per
// request with granted_id and status, in request order.
// base_id is to be written through cfg_we/cfg_wdata only while no request is in
// flight; the block does not enforce this. a request does the registered read of
// the free stack or in-use ram when taken in S_IDLE, then updates and writes back
// in S_EXEC; a new request is taken only after that write-back. the result waits
// in an output register, so the next request can be taken while the previous
// result is still unclaimed. a full output register and a stalled rsp hold S_EXEC.
// reset loads base_id with 300 and makes the pool full with the highest id on top;
// no clearing pass runs: a low-water mark of the stack pointer tells which ram
// entries have never been written, and those read as their reset contents.
`default_nettype none

module free_stack_id_allocator #(
    parameter int POOL_SIZE = fsia_pkg::POOL_SIZE_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [fsia_pkg::BASE_W-1:0]  cfg_wdata,
    fsia_req_if.sink                          req,
    fsia_rsp_if.source                        rsp
);

    localparam int OFF_W = $clog2(POOL_SIZE);
    localparam int ID_W  = fsia_pkg::ID_W;
    localparam logic [OFF_W:0] POOL_TOP = (OFF_W+1)'(POOL_SIZE);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t                         state_reg, state_next;
    logic [fsia_pkg::BASE_W-1:0]    base_reg;
    logic [OFF_W:0]                 top_reg, top_next;
    logic [OFF_W:0]                 low_mark_reg, low_mark_next;
    logic                           mode_reg;
    logic                           empty_reg;
    logic                           oor_reg;
    logic [OFF_W-1:0]               off_reg;
    logic                           out_valid_reg, out_valid_next;
    logic [ID_W-1:0]                out_id_reg;
    fsia_pkg::status_t              out_status_reg;

    logic                           accept;
    logic                           finish;
    logic [ID_W-1:0]                rel_diff;
    logic                           rel_oor;
    logic [OFF_W-1:0]               pop_addr;

    logic                           stack_we;
    logic [OFF_W-1:0]               stack_rdata;
    logic                           use_we;
    logic                           use_wdata;
    logic                           use_rdata;
    logic [OFF_W-1:0]               alloc_off;
    logic                           in_use;
    logic [ID_W-1:0]                res_id;
    fsia_pkg::status_t              res_status;

    assign accept   = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign finish   = (state_reg == S_EXEC) && (!out_valid_reg || rsp.ready);

    assign rel_diff = req.release_id - {1'b0, base_reg};
    assign rel_oor  = {1'b0, rel_diff} >= 17'(POOL_SIZE);
    assign pop_addr = OFF_W'(top_reg - 1'b1);

    // offsets below the low-water mark were never written: stack entry i holds i,
    // and offset i has never been granted
    assign alloc_off = ({1'b0, off_reg} < low_mark_reg) ? off_reg : stack_rdata;
    assign in_use    = ({1'b0, off_reg} >= low_mark_reg) && use_rdata;

    always_comb
    begin
        res_id        = '0;
        res_status    = fsia_pkg::ST_NONE_FREE;
        stack_we      = 1'b0;
        use_we        = 1'b0;
        use_wdata     = 1'b0;
        top_next      = top_reg;
        low_mark_next = low_mark_reg;
        if (mode_reg == fsia_pkg::MODE_ALLOC)
        begin
            if (!empty_reg)
            begin
                res_status = fsia_pkg::ST_ALLOCATED;
                res_id     = ID_W'(base_reg) + ID_W'(alloc_off);
                use_we     = finish;
                use_wdata  = 1'b1;
                top_next   = top_reg - 1'b1;
                if ({1'b0, off_reg} < low_mark_reg)
                begin
                    low_mark_next = {1'b0, off_reg};
                end
            end
        end
        else
        begin
            if (oor_reg)
            begin
                res_status = fsia_pkg::ST_OUT_OF_RANGE;
            end
            else if (!in_use)
            begin
                res_status = fsia_pkg::ST_NOT_IN_USE;
            end
            else
            begin
                res_status = fsia_pkg::ST_RELEASED;
                use_we     = finish;
                use_wdata  = 1'b0;
                if (top_reg < POOL_TOP)
                begin
                    stack_we = finish;
                    top_next = top_reg + 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (finish)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = finish || (out_valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            base_reg      <= fsia_pkg::BASE_RESET;
            top_reg       <= POOL_TOP;
            low_mark_reg  <= POOL_TOP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                base_reg <= cfg_wdata;
            end
            if (finish)
            begin
                top_reg      <= top_next;
                low_mark_reg <= low_mark_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= req.mode;
            empty_reg <= (top_reg == '0);
            oor_reg   <= rel_oor;
            off_reg   <= (req.mode == fsia_pkg::MODE_RELEASE) ? rel_diff[OFF_W-1:0] : pop_addr;
        end
        if (finish)
        begin
            out_id_reg     <= res_id;
            out_status_reg <= res_status;
        end
    end

    fsia_ram #(
        .WIDTH (OFF_W),
        .DEPTH (POOL_SIZE)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stack_we),
        .waddr (top_reg[OFF_W-1:0]),
        .wdata (off_reg),
        .re    (accept),
        .raddr (pop_addr),
        .rdata (stack_rdata)
    );

    fsia_ram #(
        .WIDTH (1),
        .DEPTH (POOL_SIZE)
    ) u_use_ram (
        .clk   (clk),
        .we    (use_we),
        .waddr ((mode_reg == fsia_pkg::MODE_ALLOC) ? alloc_off : off_reg),
        .wdata (use_wdata),
        .re    (accept),
        .raddr (rel_diff[OFF_W-1:0]),
        .rdata (use_rdata)
    );

    assign rsp.valid      = out_valid_reg;
    assign rsp.granted_id = out_id_reg;
    assign rsp.status     = out_status_reg;

    a_low_mark_le_top: assert property (@(posedge clk) disable iff (!rst_n)
        low_mark_reg <= top_reg)
        else $error("low-water mark above stack pointer");

    a_top_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= POOL_TOP)
        else $error("stack pointer beyond pool size");

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC))
        else $error("accepted transaction did not start execution");

    a_id_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != fsia_pkg::ST_ALLOCATED)) |-> (rsp.granted_id == '0))
        else $error("nonzero granted_id on a failed or release transaction");

    a_push_only_release: assert property (@(posedge clk) disable iff (!rst_n)
        stack_we |-> ((mode_reg == fsia_pkg::MODE_RELEASE) && finish))
        else $error("stack write outside a release write-back");

endmodule

`default_nettype wire

### tb/tb_free_stack_id_allocator.sv
// self-checking testbench for the free stack id allocator: LIFO grants, releases, base changes
`default_nettype none

module tb_free_stack_id_allocator;

    localparam int ID_W        = fsia_pkg::ID_W;
    localparam int BASE_W      = fsia_pkg::BASE_W;
    localparam int POOL        = 4096;
    localparam int OFF_W       = $clog2(POOL);
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_SHOWN   = 10;
    localparam int LONG_HOLD   = 400;
    localparam int MIX_ITEMS   = 108;

    typedef struct {
        fsia_pkg::mode_t mode;
        logic [ID_W-1:0] release_id;
    } id_request_t;

    typedef struct {
        logic [ID_W-1:0]   granted_id;
        fsia_pkg::status_t status;
    } id_result_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [BASE_W-1:0] cfg_wdata = '0;

    fsia_req_if req_ch ();
    fsia_rsp_if rsp_ch ();

    free_stack_id_allocator #(
        .POOL_SIZE (POOL)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow copy of the pool
    logic [OFF_W-1:0]  shadow_stack [POOL];
    bit                shadow_in_use [POOL];
    int                shadow_free;
    logic [BASE_W-1:0] shadow_base;

    id_request_t pending_requests [$];
    id_result_t  expected_grants [$];
    id_request_t offered;
    bit          req_busy      = 1'b0;
    int          accepted_reqs = 0;
    int          burst_left    = 0;
    int          gap_left      = 0;
    int          run_left      = 0;
    int          stall_left    = 0;
    int          hold_left     = 0;
    int          hold_at       = 32'h7fffffff;
    bit          hold_done     = 1'b0;
    int          error_count   = 0;
    int          cycle_count   = 0;
    int          status_seen [5] = '{default: 0};

    function automatic id_result_t predict_grant(id_request_t r);
        id_result_t      res;
        logic [ID_W-1:0] off;
        res.granted_id = '0;
        if (r.mode == fsia_pkg::MODE_ALLOC)
        begin
            if (shadow_free == 0)
            begin
                res.status = fsia_pkg::ST_NONE_FREE;
            end
            else
            begin
                shadow_free--;
                off = ID_W'(shadow_stack[shadow_free]);
                shadow_in_use[off] = 1'b1;
                res.granted_id = ID_W'(shadow_base) + off;
                res.status = fsia_pkg::ST_ALLOCATED;
            end
        end
        else
        begin
            off = r.release_id - ID_W'(shadow_base);
            if (off >= POOL)
            begin
                res.status = fsia_pkg::ST_OUT_OF_RANGE;
            end
            else if (!shadow_in_use[off])
            begin
                res.status = fsia_pkg::ST_NOT_IN_USE;
            end
            else
            begin
                shadow_in_use[off] = 1'b0;
                shadow_stack[shadow_free] = off[OFF_W-1:0];
                shadow_free++;
                res.status = fsia_pkg::ST_RELEASED;
            end
        end
        return res;
    endfunction

    // request driver: bursts with random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                expected_grants.push_back(predict_grant(offered));
                accepted_reqs++;
                req_busy = 1'b0;
                if (burst_left > 0)
                    burst_left--;
            end
            if (!(req_ch.valid && !req_ch.ready))
            begin
                if (burst_left == 0 && gap_left == 0)
                begin
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                             : $urandom_range(1, 24);
                end
                if (gap_left > 0)
                begin
                    req_ch.valid <= 1'b0;
                    gap_left--;
                end
                else if (pending_requests.size() > 0)
                begin
                    offered = pending_requests.pop_front();
                    req_busy = 1'b1;
                    req_ch.valid      <= 1'b1;
                    req_ch.mode       <= offered.mode;
                    req_ch.release_id <= offered.release_id;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // response ready pattern, plus one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else if (!hold_done && accepted_reqs >= hold_at)
        begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            rsp_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (run_left == 0 && stall_left == 0)
            begin
                run_left   = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 10);
                stall_left = $urandom_range(0, 4);
            end
            if (run_left > 0)
            begin
                rsp_ch.ready <= 1'b1;
                run_left--;
            end
            else
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
        end
    end

    // response monitor
    always @(posedge clk)
    begin
        id_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_grants.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_SHOWN)
                    $display("unexpected transaction: granted_id %0d status %0d",
                             rsp_ch.granted_id, rsp_ch.status);
            end
            else
            begin
                want = expected_grants.pop_front();
                status_seen[int'(want.status)]++;
                if (rsp_ch.granted_id !== want.granted_id || rsp_ch.status !== want.status)
                begin
                    error_count++;
                    if (error_count <= MAX_SHOWN)
                        $display("mismatch: expected id %0d status %s, got id %0d status %0d",
                                 want.granted_id, want.status.name(),
                                 rsp_ch.granted_id, rsp_ch.status);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic push_req(input fsia_pkg::mode_t m, input logic [ID_W-1:0] rid);
        id_request_t r;
        r.mode = m;
        r.release_id = rid;
        pending_requests.push_back(r);
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_requests.size() != 0 || req_busy || expected_grants.size() != 0);
    endtask

    task automatic write_base(input logic [BASE_W-1:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        shadow_base = v;
        repeat (2) @(posedge clk);
    endtask

    initial
    begin
        logic [ID_W-1:0]   b;
        logic [ID_W-1:0]   recent [$];
        logic [BASE_W-1:0] mix_bases [4];
        int                roll;
        int                noise;

        req_ch.valid      = 1'b0;
        req_ch.mode       = 1'b0;
        req_ch.release_id = '0;
        rsp_ch.ready      = 1'b0;

        shadow_base = fsia_pkg::BASE_RESET;
        for (int i = 0; i < POOL; i++)
        begin
            shadow_stack[i]  = OFF_W'(i);
            shadow_in_use[i] = 1'b0;
        end
        shadow_free = POOL;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset base: grants from the top, release edge cases
        b = ID_W'(fsia_pkg::BASE_RESET);
        push_req(fsia_pkg::MODE_ALLOC, 16'hFFFF);
        push_req(fsia_pkg::MODE_ALLOC, 16'h0000);
        push_req(fsia_pkg::MODE_RELEASE, ID_W'(b + POOL - 1));
        push_req(fsia_pkg::MODE_RELEASE, ID_W'(b + POOL - 1));
        push_req(fsia_pkg::MODE_RELEASE, ID_W'(b - 1));
        push_req(fsia_pkg::MODE_RELEASE, ID_W'(b + POOL));
        push_req(fsia_pkg::MODE_RELEASE, b);
        push_req(fsia_pkg::MODE_RELEASE, 16'h0000);
        push_req(fsia_pkg::MODE_RELEASE, 16'hFFFF);
        push_req(fsia_pkg::MODE_ALLOC, ID_W'($urandom));
        wait_drained();

        // base moved while ids are held
        write_base('0);
        b = '0;
        push_req(fsia_pkg::MODE_RELEASE, ID_W'(b + POOL - 2));
        push_req(fsia_pkg::MODE_ALLOC, ID_W'($urandom));
        push_req(fsia_pkg::MODE_RELEASE, ID_W'(b + POOL));
        push_req(fsia_pkg::MODE_RELEASE, b);
        wait_drained();

        write_base(15'h7FFF);
        b = 16'h7FFF;
        push_req(fsia_pkg::MODE_ALLOC, ID_W'($urandom));
        push_req(fsia_pkg::MODE_RELEASE, ID_W'(b - 1));
        push_req(fsia_pkg::MODE_RELEASE, ID_W'(b + POOL - 1));
        push_req(fsia_pkg::MODE_RELEASE, 16'hFFFF);
        wait_drained();

        // mixed traffic, releases aimed at the recently granted top of the pool
        mix_bases[0] = '0;
        mix_bases[1] = 15'h7FFF;
        mix_bases[2] = BASE_W'($urandom_range(0, 32767));
        mix_bases[3] = fsia_pkg::BASE_RESET;
        for (int p = 0; p < 4; p++)
        begin
            write_base(mix_bases[p]);
            b = ID_W'(mix_bases[p]);
            recent.delete();
            if (p == 1)
                hold_at = accepted_reqs + 40;
            for (int i = 0; i < MIX_ITEMS; i++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 45)
                begin
                    push_req(fsia_pkg::MODE_ALLOC, ID_W'($urandom));
                end
                else if (roll < 85 || recent.size() == 0)
                begin
                    recent.push_back(ID_W'(b + POOL - 1 - $urandom_range(0, 63)));
                    if (recent.size() > 16)
                        void'(recent.pop_front());
                    push_req(fsia_pkg::MODE_RELEASE, recent[$]);
                end
                else if (roll < 93)
                begin
                    push_req(fsia_pkg::MODE_RELEASE,
                             recent[$urandom_range(0, recent.size() - 1)]);
                end
                else
                begin
                    noise = $urandom_range(0, 2);
                    if (noise == 0)
                        push_req(fsia_pkg::MODE_RELEASE, ID_W'(b - 1));
                    else if (noise == 1)
                        push_req(fsia_pkg::MODE_RELEASE, ID_W'(b + POOL));
                    else
                        push_req(fsia_pkg::MODE_RELEASE, ID_W'($urandom));
                end
            end
            wait_drained();
        end

        repeat (20) @(posedge clk);

        $display("run covered %0d requests: %0d granted, %0d none free, %0d released,",
                 accepted_reqs, status_seen[fsia_pkg::ST_ALLOCATED],
                 status_seen[fsia_pkg::ST_NONE_FREE], status_seen[fsia_pkg::ST_RELEASED]);
        $display("  %0d out of range, %0d not in use; bases 300, 0, 32767 and random",
                 status_seen[fsia_pkg::ST_OUT_OF_RANGE], status_seen[fsia_pkg::ST_NOT_IN_USE]);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
